// ===== hw/rtl/softened_gravity_pair_factor_core_defines.svh =====
// Assertion macros for the pair factor core.
`ifndef SOFTENED_GRAVITY_PAIR_FACTOR_CORE_DEFINES_SVH
`define SOFTENED_GRAVITY_PAIR_FACTOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define SGPF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgpf assertion failed");
`define SGPF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sgpf assertion failed");
`else
`define SGPF_ASSERT(lbl, clk, rst_n, prop)
`define SGPF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/sgpf_pkg.sv =====
package sgpf_pkg;

  localparam int SGPF_FRAC_BITS_DEF = 16;
  localparam int SGPF_QW = 64;
  localparam int SGPF_CW = 192;
  localparam int SGPF_W = 322;
  localparam int SGPF_IDX_W = 2;

  localparam logic [SGPF_IDX_W-1:0] CFG_EFF_CONST = 2'd0;
  localparam logic [SGPF_IDX_W-1:0] CFG_SOFTEN = 2'd1;

  localparam logic [31:0] EFF_CONST_RST = 32'd65536;
  localparam logic [31:0] SOFTEN_RST = 32'd0;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_INVALID = 2'd1,
    ST_SING = 2'd2
  } sgpf_status_t;

  typedef struct packed {
    logic v;
    sgpf_status_t st;
    logic [SGPF_QW-1:0] quo;
    logic [SGPF_W-1:0] rem;
    logic [SGPF_W-1:0] acc;
    logic [SGPF_CW-1:0] cube;
  } sgpf_root_t;

endpackage

// ===== hw/rtl/sgpf_ifs.sv =====
interface sgpf_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] body_mass;
  logic signed [31:0] distance_squared;
  modport source(output valid, output body_mass, output distance_squared, input ready);
  modport sink(input valid, input body_mass, input distance_squared, output ready);
endinterface

interface sgpf_out_if;
  logic valid;
  logic ready;
  logic [63:0] pair_factor;
  logic [1:0] pair_status;
  modport source(output valid, output pair_factor, output pair_status, input ready);
  modport sink(input valid, input pair_factor, input pair_status, output ready);
endinterface

// ===== hw/rtl/softened_gravity_pair_factor_core.sv =====
// Softened gravity pair factor core.
// Input channel in_ch carries body_mass and distance_squared (signed Q16.16).
// Output channel out_ch returns pair_factor = G*m/(s*sqrt(s)) in unsigned Q32.32,
// rounded toward zero and saturated, with pair_status (valid, invalid, singularity).
// The cfg port writes effective_constant (index 0) and softening_length (index 1)
// and the user must write only while no transaction is in flight (unchecked).
// From input transaction to result, six stages form s, s^3 and the squared scaled
// numerator, 64 stages settle one quotient bit each by shift, add and compare, and
// one output register holds the result.
// Throughput is one transaction per cycle while the receiver keeps ready high.
// The whole pipeline advances together; when the receiver holds ready low with a
// result waiting, every stage holds and in_ch.ready drops until it is taken.
// Synchronous reset empties the pipeline and restores the register defaults.
module softened_gravity_pair_factor_core #(
  parameter int FRAC_BITS = sgpf_pkg::SGPF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sgpf_in_if.sink                            in_ch,
  sgpf_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [sgpf_pkg::SGPF_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                        cfg_wdata
);
  import sgpf_pkg::*;
  `include "softened_gravity_pair_factor_core_defines.svh"

  localparam int ASH = 2 * (FRAC_BITS + 32);

  logic [31:0] eff_const_r, soften_r;
  logic adv;

  logic v1_r, inv1_r;
  logic [62:0] gm1_r;
  logic [63:0] eps2_1_r, dsh1_r;

  logic v2_r;
  sgpf_status_t st2_r;
  logic [62:0] gm2_r;
  logic [63:0] s2_r;
  logic [64:0] ssum;

  logic v3_r;
  sgpf_status_t st3_r;
  logic [63:0] s3_r, sll_r, slh_r, shh_r, gll_r, glh_r, ghh_r;

  logic v4_r;
  sgpf_status_t st4_r;
  logic [63:0] s4_r;
  logic [127:0] sq4_r, a4_r;
  logic [129:0] sq_sum, a_sum;

  logic v5_r;
  sgpf_status_t st5_r;
  logic [127:0] a5_r;
  logic [63:0] pp5_r [0:7];

  sgpf_root_t head_r;
  logic [SGPF_CW+3:0] cube_sum;

  sgpf_root_t chain [0:SGPF_QW];

  logic out_valid_r;
  logic [63:0] factor_r;
  sgpf_status_t status_r;

  assign adv = out_ch.ready || !out_valid_r;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_const_r <= EFF_CONST_RST;
      soften_r <= SOFTEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EFF_CONST: eff_const_r <= cfg_wdata;
        CFG_SOFTEN: soften_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      inv1_r <= (eff_const_r == 32'd0) || in_ch.body_mass[31] || in_ch.distance_squared[31];
      gm1_r <= 63'(eff_const_r * in_ch.body_mass[30:0]);
      eps2_1_r <= soften_r * soften_r;
      dsh1_r <= 64'(in_ch.distance_squared[30:0]) << FRAC_BITS;
    end
  end

  assign ssum = {1'b0, dsh1_r} + {1'b0, eps2_1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
      gm2_r <= gm1_r;
      s2_r <= ssum[63:0];
      if (inv1_r || ssum[64]) begin
        st2_r <= ST_INVALID;
      end else if (ssum[63:0] == 64'd0) begin
        st2_r <= ST_SING;
      end else begin
        st2_r <= ST_VALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
      st3_r <= st2_r;
      s3_r <= s2_r;
      sll_r <= s2_r[31:0] * s2_r[31:0];
      slh_r <= s2_r[31:0] * s2_r[63:32];
      shh_r <= s2_r[63:32] * s2_r[63:32];
      gll_r <= gm2_r[31:0] * gm2_r[31:0];
      glh_r <= gm2_r[31:0] * {1'b0, gm2_r[62:32]};
      ghh_r <= {1'b0, gm2_r[62:32]} * {1'b0, gm2_r[62:32]};
    end
  end

  assign sq_sum = 130'(sll_r) + (130'(slh_r) << 33) + (130'(shh_r) << 64);
  assign a_sum = 130'(gll_r) + (130'(glh_r) << 33) + (130'(ghh_r) << 64);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
      st4_r <= st3_r;
      s4_r <= s3_r;
      sq4_r <= sq_sum[127:0];
      a4_r <= a_sum[127:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
      st5_r <= st4_r;
      a5_r <= a4_r;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp5_r[2*i+j] <= sq4_r[32*i +: 32] * s4_r[32*j +: 32];
        end
      end
    end
  end

  always_comb begin
    cube_sum = '0;
    for (int k = 0; k < 8; k++) begin
      cube_sum = cube_sum + ((SGPF_CW+4)'(pp5_r[k]) << (32 * ((k / 2) + (k % 2))));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (adv) begin
      head_r.v <= v5_r;
      head_r.st <= st5_r;
      head_r.quo <= '0;
      head_r.rem <= SGPF_W'(a5_r) << ASH;
      head_r.acc <= '0;
      head_r.cube <= cube_sum[SGPF_CW-1:0];
    end
  end

  assign chain[0] = head_r;

  for (genvar g = 0; g < SGPF_QW; g++) begin : g_root
    sgpf_root_stage #(
      .B(SGPF_QW - 1 - g)
    ) u_stage (
      .clk(clk),
      .rst_n(rst_n),
      .en(adv),
      .d(chain[g]),
      .q_r(chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r <= ST_VALID;
      factor_r <= '0;
    end else if (adv) begin
      out_valid_r <= chain[SGPF_QW].v;
      status_r <= chain[SGPF_QW].st;
      factor_r <= (chain[SGPF_QW].st == ST_VALID) ? chain[SGPF_QW].quo : 64'd0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pair_factor = factor_r;
  assign out_ch.pair_status = status_r;

  `SGPF_ASSERT(a_zero_unless_valid, clk, rst_n,
    (out_valid_r && status_r != ST_VALID) |-> (factor_r == 64'd0))
  `SGPF_ASSERT(a_status_range, clk, rst_n,
    out_valid_r |-> (status_r == ST_VALID || status_r == ST_INVALID || status_r == ST_SING))
  `SGPF_ASSERT(a_hold_on_stall, clk, rst_n,
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(factor_r) && $stable(status_r)))
  `SGPF_ASSERT_ALWAYS(a_empty_after_reset, clk,
    !rst_n |=> (!out_valid_r && !head_r.v))
endmodule

// ===== hw/rtl/sgpf_root_stage.sv =====
module sgpf_root_stage #(
  parameter int B = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  sgpf_pkg::sgpf_root_t d,
  output sgpf_pkg::sgpf_root_t q_r
);
  import sgpf_pkg::*;

  localparam int SH1 = B + 1;
  localparam int SH2 = 2 * B;

  logic [SGPF_W-1:0] delta;
  logic take;
  sgpf_root_t q_nxt;

  always_comb begin
    delta = (d.acc << SH1) + (SGPF_W'(d.cube) << SH2);
    take = (delta <= d.rem);
    q_nxt = d;
    if (take) begin
      q_nxt.rem = d.rem - delta;
      q_nxt.acc = d.acc + (SGPF_W'(d.cube) << B);
      q_nxt.quo = d.quo | (SGPF_QW'(1) << B);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end
endmodule

// ===== verif/tb_softened_gravity_pair_factor_core.sv =====
`timescale 1ns / 100ps

module tb_softened_gravity_pair_factor_core;
  import sgpf_pkg::*;

  localparam int FRAC = SGPF_FRAC_BITS_DEF;
  localparam logic [SGPF_IDX_W-1:0] CFG_SPARE = 2'd2;
  localparam int PIPE_CYCLES = 80;

  typedef struct {
    logic [63:0] factor;
    sgpf_status_t status;
  } pair_result_t;

  class pair_factor_board;
    logic [31:0] grav_const;
    logic [31:0] soften;
    pair_result_t awaited[$];
    int errors;

    function new();
      grav_const = EFF_CONST_RST;
      soften = SOFTEN_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [SGPF_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == CFG_EFF_CONST) begin
        grav_const = val;
      end else if (idx == CFG_SOFTEN) begin
        soften = val;
      end
    endfunction

    function logic [63:0] force_factor(logic [63:0] gm, logic [63:0] s);
      logic [383:0] num;
      logic [383:0] s_cube;
      logic [383:0] trial;
      logic [63:0] q;
      logic [63:0] cand;
      num = {320'b0, gm};
      num = num * num;
      num = num << (2 * (FRAC + 32));
      s_cube = {320'b0, s};
      s_cube = s_cube * s_cube * s_cube;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = q | (64'd1 << b);
        trial = {320'b0, cand};
        trial = trial * trial * s_cube;
        if (trial <= num) q = cand;
      end
      return q;
    endfunction

    function void note_input(logic [31:0] m, logic [31:0] d);
      pair_result_t r;
      logic [63:0] dsh;
      logic [63:0] eps2;
      logic [63:0] s;
      r.factor = '0;
      if (grav_const == 0 || m[31] || d[31]) begin
        r.status = ST_INVALID;
      end else begin
        dsh = {32'b0, d} << FRAC;
        eps2 = {32'b0, soften} * {32'b0, soften};
        if (eps2 > ~64'd0 - dsh) begin
          r.status = ST_INVALID;
        end else begin
          s = dsh + eps2;
          if (s == 0) begin
            r.status = ST_SING;
          end else begin
            r.status = ST_VALID;
            if (m != 0) r.factor = force_factor({32'b0, grav_const} * {32'b0, m}, s);
          end
        end
      end
      awaited.push_back(r);
    endfunction

    function void check_result(logic [63:0] factor, logic [1:0] status);
      pair_result_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result transaction: pair_factor %h pair_status %0d", factor, status);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (factor !== e.factor) begin
        $error("pair_factor expected %h actual %h", e.factor, factor);
        errors++;
      end
      if (status !== e.status) begin
        $error("pair_status expected %0d actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SGPF_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;
  int stall_mode;
  int gap_max;
  bit long_hold;
  pair_factor_board board;

  sgpf_in_if in_ch();
  sgpf_out_if out_ch();

  softened_gravity_pair_factor_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #5_000_000;
    $display("softened_gravity_pair_factor_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.pair_factor, out_ch.pair_status);
  end

  always @(negedge clk) begin
    if (long_hold) begin
      out_ch.ready <= 1'b0;
      repeat (400) @(negedge clk);
      long_hold = 1'b0;
    end else if (stall_mode == 0) begin
      out_ch.ready <= 1'b1;
    end else if (stall_mode == 1) begin
      out_ch.ready <= ($urandom_range(9, 0) < 7);
    end else begin
      out_ch.ready <= ($urandom_range(9, 0) < 3);
    end
  end

  task automatic send_item(logic [31:0] m, logic [31:0] d);
    in_ch.valid <= 1'b1;
    in_ch.body_mass <= m;
    in_ch.distance_squared <= d;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(m, d);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [SGPF_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return $urandom() | 32'h8000_0000;
      2: return $urandom_range(255, 0);
      3: return $urandom() >> $urandom_range(31, 1);
      4: return 32'h7fff_ffff - $urandom_range(15, 0);
      default: return $urandom() & 32'h7fff_ffff;
    endcase
  endfunction

  task automatic random_items(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(20, 1);
        if (gap_max > 0) pause_sender($urandom_range(gap_max, 0));
      end
      burst--;
      send_item(pick_operand(), pick_operand());
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_EFF_CONST;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.body_mass = '0;
    in_ch.distance_squared = '0;
    out_ch.ready = 1'b0;
    stall_mode = 0;
    gap_max = 0;
    long_hold = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(32'h0001_0000, 32'h0001_0000);
    send_item(32'h0000_0000, 32'h0001_0000);
    send_item(32'h0001_0000, 32'h0000_0000);
    send_item(32'h8000_0000, 32'h0001_0000);
    send_item(32'h0001_0000, 32'hffff_ffff);
    send_item(32'h7fff_ffff, 32'h0000_0001);
    send_item(32'h0000_0001, 32'h7fff_ffff);
    send_item(32'h7fff_ffff, 32'h7fff_ffff);
    drain();
    write_reg(CFG_EFF_CONST, 32'hffff_ffff);
    write_reg(CFG_SOFTEN, 32'hffff_ffff);
    write_reg(CFG_SPARE, 32'h0000_0000);
    send_item(32'h7fff_ffff, 32'h0000_0000);
    send_item(32'h7fff_ffff, 32'h7fff_ffff);
    send_item(32'h0000_0001, 32'h0000_0010);
    drain();
    write_reg(CFG_SOFTEN, 32'h0000_0001);
    send_item(32'h7fff_ffff, 32'h0000_0000);
    send_item(32'h0000_0000, 32'h0000_0000);
    drain();
    write_reg(CFG_EFF_CONST, 32'h0000_0000);
    send_item(32'h0001_0000, 32'h0001_0000);
    send_item(32'h0000_0000, 32'h0000_0000);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_EFF_CONST, EFF_CONST_RST); write_reg(CFG_SOFTEN, 32'h0); end
        1: begin write_reg(CFG_EFF_CONST, 32'hffff_ffff); write_reg(CFG_SOFTEN, 32'hffff_ffff); end
        2: begin write_reg(CFG_EFF_CONST, 32'h0); write_reg(CFG_SOFTEN, $urandom()); end
        3: begin write_reg(CFG_EFF_CONST, 32'h1); write_reg(CFG_SOFTEN, 32'h1); end
        default: begin write_reg(CFG_EFF_CONST, $urandom()); write_reg(CFG_SOFTEN, $urandom()); end
      endcase
      stall_mode = phase % 3;
      gap_max = (phase % 2 == 0) ? 0 : 6;
      if (phase == 4) long_hold = 1'b1;
      random_items(phase == 2 ? 60 : 150);
      if (phase == 3) drain();
      pause_sender($urandom_range(3, 0));
      drain();
    end

    stall_mode = 0;
    drain();
    if (board.errors == 0) begin
      $display("softened_gravity_pair_factor_core verification clean");
    end else begin
      $display("softened_gravity_pair_factor_core verification failed");
    end
    $finish;
  end
endmodule
